// ----- rtl/core/gcm_pkg.sv -----
package gcm_pkg;

  localparam int unsigned POS_W      = 17;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned RGB_W      = 24;
  localparam int unsigned WORD_W     = POS_W + RGB_W;
  localparam int unsigned CNT_W      = 3;
  localparam int unsigned IDX_W      = 3;
  localparam int unsigned NUM_CHAN   = 3;

  localparam int unsigned PADDR_W    = 6;
  localparam int unsigned PDATA_W    = 64;
  localparam int unsigned IN_TDATA_W = 24;
  localparam int unsigned OUT_TDATA_W = 32;

  localparam logic [POS_W-1:0] ONE_POS = 17'h10000;

  // register indexes
  localparam logic [IDX_W-1:0] REG_STOP_COUNT = 3'd0;
  localparam logic [IDX_W-1:0] REG_STOP_WORD0 = 3'd1;

  localparam logic [WORD_W-1:0] STOP1_RESET = 41'h0FF_FFFF_FFFF;

endpackage

// ----- rtl/core/gradient_color_map.sv -----
// Piecewise-linear color gradient lookup. Each sample on s_axis (17-bit fixed
// point, 65536 = 1.0) selects the first gradient segment with
// pos[i] < sample <= pos[i+1] and returns the RGB888 color blended between its
// two stops. One sample is accepted per clock while s_axis_tready is high.
// A sample passes the segment search, the pipelined restoring divider that
// forms the blend fraction one quotient bit per stage, the channel multiplies
// and the final sum into the output buffer. A two-entry output buffer lets
// the pipeline keep taking samples after m_axis stalls until a result meets a
// full head entry; s_axis_tready then drops until the buffer drains. Gradient
// stops must be written over the APB port only while the block is idle; the
// block itself does not enforce this. Register k (count at 0, stop words at
// 1..7) sits at byte address 8*k.
module gradient_color_map
  import gcm_pkg::*;
#(
  parameter int unsigned MAX_STOPS = 7,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,

  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_W-1:0]     paddr,
  input  logic [PDATA_W-1:0]     pwdata,
  output logic [PDATA_W-1:0]     prdata,
  output logic                   pready,

  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // sample_value[16:0], zero padding above
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,

  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // segment_index[2:0], red_out[10:3], green_out[18:11], blue_out[26:19], zeros
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // found[0]
  output logic                   m_axis_tuser
);

  localparam int unsigned QW   = FRAC_BITS + 1;
  localparam int unsigned PW   = CHAN_W + QW;
  localparam logic [QW-1:0]    FullC     = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [CNT_W-1:0] MaxStopsC = CNT_W'(MAX_STOPS);

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
    logic [POS_W-1:0] rem;
    logic [POS_W-1:0] den;
    logic [QW-1:0]    quo;
    logic [RGB_W-1:0] ca;
    logic [RGB_W-1:0] cb;
  } div_t;

  typedef struct packed {
    logic                          found;
    logic [IDX_W-1:0]              idx;
    logic [NUM_CHAN-1:0][PW-1:0]   pa;
    logic [NUM_CHAN-1:0][PW-1:0]   pb;
  } mul_t;

  // ---------------- configuration ----------------
  logic [CNT_W-1:0]  stop_count_q;
  logic [WORD_W-1:0] stop_q [MAX_STOPS];
  logic              cfg_wr;
  logic [IDX_W-1:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[PADDR_W-1 -: IDX_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_count_q <= CNT_W'(2);
      for (int k = 0; k < MAX_STOPS; k++) begin
        stop_q[k] <= (k == 1) ? STOP1_RESET : '0;
      end
    end else if (cfg_wr) begin
      if (cfg_idx == REG_STOP_COUNT) begin
        stop_count_q <= pwdata[CNT_W-1:0];
      end
      for (int k = 0; k < MAX_STOPS; k++) begin
        if (cfg_idx == REG_STOP_WORD0 + IDX_W'(k)) begin
          stop_q[k] <= pwdata[WORD_W-1:0];
        end
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (cfg_idx == REG_STOP_COUNT) begin
      prdata = PDATA_W'(stop_count_q);
    end
    for (int k = 0; k < MAX_STOPS; k++) begin
      if (cfg_idx == REG_STOP_WORD0 + IDX_W'(k)) begin
        prdata = PDATA_W'(stop_q[k]);
      end
    end
  end

  // ---------------- pipeline control ----------------
  logic en;
  logic skid_v_q, out_v_q;
  logic m_v_q, p_v_q;
  logic [FRAC_BITS:0] d_v_q;

  assign en            = ~skid_v_q;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
      d_v_q <= '0;
      p_v_q <= 1'b0;
    end else if (en) begin
      m_v_q <= s_axis_tvalid;
      d_v_q <= {d_v_q[FRAC_BITS-1:0], m_v_q};
      p_v_q <= d_v_q[FRAC_BITS];
    end
  end

  // ---------------- segment search ----------------
  logic [POS_W-1:0] sample;
  logic [CNT_W-1:0] n_eff;
  div_t             m_d, m_q;

  assign sample = s_axis_tdata[POS_W-1:0];
  assign n_eff  = (stop_count_q > MaxStopsC) ? MaxStopsC : stop_count_q;

  always_comb begin
    logic [POS_W-1:0] lo, hi;
    m_d = '0;
    for (int i = MAX_STOPS - 2; i >= 0; i--) begin
      lo = stop_q[i][RGB_W +: POS_W];
      hi = stop_q[i+1][RGB_W +: POS_W];
      if (sample <= ONE_POS && CNT_W'(i + 1) < n_eff && sample > lo && sample <= hi) begin
        m_d.found = 1'b1;
        m_d.idx   = IDX_W'(i);
        m_d.rem   = sample - lo;
        m_d.den   = hi - lo;
        m_d.ca    = stop_q[i][RGB_W-1:0];
        m_d.cb    = stop_q[i+1][RGB_W-1:0];
      end
    end
  end

  // ---------------- restoring divider, one quotient bit per stage ----------------
  div_t d_d [FRAC_BITS+1];
  div_t d_q [FRAC_BITS+1];

  always_comb begin
    logic [POS_W:0] r2;
    logic           ge;
    d_d[0]     = m_q;
    ge         = m_q.rem >= m_q.den;
    d_d[0].rem = ge ? m_q.rem - m_q.den : m_q.rem;
    d_d[0].quo = QW'(ge);
    for (int k = 1; k <= FRAC_BITS; k++) begin
      d_d[k]     = d_q[k-1];
      r2         = {d_q[k-1].rem, 1'b0};
      ge         = r2 >= {1'b0, d_q[k-1].den};
      d_d[k].rem = ge ? POS_W'(r2 - {1'b0, d_q[k-1].den}) : r2[POS_W-1:0];
      d_d[k].quo = {d_q[k-1].quo[QW-2:0], ge};
    end
  end

  // ---------------- blend multiplies ----------------
  mul_t p_d, p_q;

  always_comb begin
    logic [QW-1:0] t, inv;
    t         = d_q[FRAC_BITS].quo;
    inv       = FullC - t;
    p_d.found = d_q[FRAC_BITS].found;
    p_d.idx   = d_q[FRAC_BITS].idx;
    for (int c = 0; c < NUM_CHAN; c++) begin
      p_d.pa[c] = d_q[FRAC_BITS].ca[CHAN_W*c +: CHAN_W] * inv;
      p_d.pb[c] = d_q[FRAC_BITS].cb[CHAN_W*c +: CHAN_W] * t;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_q <= m_d;
      for (int k = 0; k <= FRAC_BITS; k++) begin
        d_q[k] <= d_d[k];
      end
      p_q <= p_d;
    end
  end

  // ---------------- output sum and two-entry buffer ----------------
  logic [OUT_TDATA_W-1:0] new_data;
  logic [OUT_TDATA_W-1:0] out_data_q, skid_data_q;
  logic                   out_user_q, skid_user_q;
  logic                   push, pop;

  always_comb begin
    logic [PW:0]                     sum;
    logic [NUM_CHAN-1:0][CHAN_W-1:0] ch;
    for (int c = 0; c < NUM_CHAN; c++) begin
      sum   = {1'b0, p_q.pa[c]} + {1'b0, p_q.pb[c]};
      ch[c] = p_q.found ? sum[FRAC_BITS +: CHAN_W] : '0;
    end
    // ch[2] red, ch[1] green, ch[0] blue
    new_data = OUT_TDATA_W'({ch[0], ch[1], ch[2], p_q.found ? p_q.idx : IDX_W'(0)});
  end

  assign push = en & p_v_q;
  assign pop  = out_v_q & m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (pop) begin
        skid_v_q <= 1'b0;
      end
    end else if (push) begin
      if (out_v_q && !pop) begin
        skid_v_q <= 1'b1;
      end else begin
        out_v_q <= 1'b1;
      end
    end else if (pop) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (pop) begin
        out_data_q <= skid_data_q;
        out_user_q <= skid_user_q;
      end
    end else if (push) begin
      if (out_v_q && !pop) begin
        skid_data_q <= new_data;
        skid_user_q <= p_q.found;
      end else begin
        out_data_q <= new_data;
        out_user_q <= p_q.found;
      end
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // ---------------- assertions ----------------
  a_skid_needs_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid entry held without a head entry");

  a_miss_is_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("unmatched sample carries nonzero payload");

  a_index_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      (int'(m_axis_tdata[IDX_W-1:0]) + 2 <= int'(MAX_STOPS)))
    else $error("segment index beyond last segment");

endmodule

// ----- dv/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gcm_pkg::*;

  localparam int unsigned NUM_STOPS      = 7;
  localparam int unsigned FRAC           = 16;
  localparam int unsigned DRAIN_CYCLES   = 30;
  localparam int unsigned RX_HOLD_CYCLES = 200;
  localparam int unsigned STALL_LIMIT    = 2000;
  localparam int unsigned IDLE_PCT       = 35;
  localparam int unsigned NUM_PHASES     = 9;
  localparam int unsigned PHASE_ITEMS    = 60;

  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  seg;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } color_t;

  typedef struct {
    bit                is_cfg;
    logic [IDX_W-1:0]  reg_idx;
    logic [WORD_W-1:0] wdata;
    logic [POS_W-1:0]  sample;
    bit                known;
    color_t            want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [PADDR_W-1:0]     paddr;
  logic [PDATA_W-1:0]     pwdata;
  logic [PDATA_W-1:0]     prdata;
  logic                   pready;

  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;

  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;

  // gradient mirror
  logic [CNT_W-1:0]  map_count;
  logic [WORD_W-1:0] map_word [NUM_STOPS];

  color_t      color_q [$];
  stim_row_t   plan [$];
  int unsigned errors       = 0;
  int unsigned quiet_cycles = 0;
  int unsigned rx_hold_left = 0;
  bit          rx_hold_req  = 1'b0;
  bit          calm         = 1'b0;
  bit          streaming    = 1'b0;

  always #2ns clk_i = ~clk_i;

  gradient_color_map i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  task automatic flag_mismatch(input string what);
    errors++;
    $display("%0t ns: %s", $realtime, what);
  endtask

  function automatic logic [CHAN_W-1:0] blend(input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] b,
                                              input longint unsigned t);
    longint unsigned mix;
    mix = (longint'(a) * ((64'd1 << FRAC) - t) + longint'(b) * t) >> FRAC;
    return mix[CHAN_W-1:0];
  endfunction

  function automatic color_t map_sample(input logic [POS_W-1:0] v);
    color_t            c;
    logic [POS_W-1:0]  lo;
    logic [POS_W-1:0]  hi;
    logic [WORD_W-1:0] wa;
    logic [WORD_W-1:0] wb;
    longint unsigned   t;
    c = '0;
    if (v > ONE_POS || map_count < 2) return c;
    for (int i = 0; i + 1 < int'(map_count); i++) begin
      wa = map_word[i];
      wb = map_word[i+1];
      lo = wa[WORD_W-1:RGB_W];
      hi = wb[WORD_W-1:RGB_W];
      if (v > lo && v <= hi) begin
        t = (longint'(v - lo) << FRAC) / longint'(hi - lo);
        c.found = 1'b1;
        c.seg   = IDX_W'(i);
        c.red   = blend(wa[23:16], wb[23:16], t);
        c.green = blend(wa[15:8], wb[15:8], t);
        c.blue  = blend(wa[7:0], wb[7:0], t);
        return c;
      end
    end
    return c;
  endfunction

  function automatic logic [WORD_W-1:0] stop_word(input logic [POS_W-1:0] pos,
                                                  input logic [RGB_W-1:0] rgb);
    return {pos, rgb};
  endfunction

  function automatic stim_row_t cfg_row(input logic [IDX_W-1:0] idx,
                                        input logic [WORD_W-1:0] data);
    stim_row_t r;
    r = '{is_cfg: 1'b1, reg_idx: idx, wdata: data, sample: '0, known: 1'b0, want: '0};
    return r;
  endfunction

  function automatic stim_row_t sample_row(input logic [POS_W-1:0] v);
    stim_row_t r;
    r = '{is_cfg: 1'b0, reg_idx: '0, wdata: '0, sample: v, known: 1'b0, want: '0};
    return r;
  endfunction

  function automatic stim_row_t known_row(input logic [POS_W-1:0] v, input color_t want);
    stim_row_t r;
    r = '{is_cfg: 1'b0, reg_idx: '0, wdata: '0, sample: v, known: 1'b1, want: want};
    return r;
  endfunction

  // one APB transaction, starting and ending on a rising edge
  task automatic apb_xfer(input logic wr, input logic [IDX_W-1:0] idx,
                          input logic [PDATA_W-1:0] wd, output logic [PDATA_W-1:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PADDR_W'(idx) << 3;
    pwdata  <= wd;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    logic [PDATA_W-1:0] rd;
    logic [PDATA_W-1:0] stored;
    apb_xfer(1'b1, idx, PDATA_W'(data), rd);
    if (idx == REG_STOP_COUNT) begin
      map_count = data[CNT_W-1:0];
      stored    = PDATA_W'(map_count);
    end else begin
      map_word[idx - REG_STOP_WORD0] = data;
      stored = PDATA_W'(data);
    end
    apb_xfer(1'b0, idx, '0, rd);
    if (rd !== stored)
      flag_mismatch($sformatf("register %0d reads %h, wrote %h", idx, rd, stored));
  endtask

  task automatic send_sample(input logic [POS_W-1:0] v, input bit known, input color_t want);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(v);
    do @(posedge clk_i); while (!s_axis_tready);
    color_q.push_back(known ? want : map_sample(v));
    streaming = 1'b1;
  endtask

  task automatic pause_and_drain();
    if (streaming) s_axis_tvalid <= 1'b0;
    streaming = 1'b0;
    while (color_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // result checker and receiver backpressure
  initial begin
    color_t got;
    color_t want;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got = '{found: m_axis_tuser, seg: m_axis_tdata[2:0], red: m_axis_tdata[10:3],
                green: m_axis_tdata[18:11], blue: m_axis_tdata[26:19]};
        if (color_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected color %h", got));
        end else begin
          want = color_q.pop_front();
          if (got !== want)
            flag_mismatch($sformatf("color got f=%b seg=%0d rgb=%h%h%h, exp f=%b seg=%0d rgb=%h%h%h",
                                    got.found, got.seg, got.red, got.green, got.blue,
                                    want.found, want.seg, want.red, want.green, want.blue));
        end
      end
      if (rx_hold_left != 0) begin
        rx_hold_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_hold_req) begin
        rx_hold_req  = 1'b0;
        rx_hold_left = RX_HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // watchdog: cycles with no transaction anywhere
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable && pready)) begin
        quiet_cycles = 0;
      end else if (++quiet_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    logic [POS_W-1:0]  v;
    logic [WORD_W-1:0] w;
    int unsigned       n;
    int unsigned       k;
    int unsigned       pick;
    int unsigned       pos_q [$];

    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    map_count     = CNT_W'(2);
    foreach (map_word[i]) map_word[i] = '0;
    map_word[1]   = STOP1_RESET;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset gradient: black at 0 to white at 65535
    plan.push_back(known_row(17'd0, '0));
    plan.push_back(known_row(17'd1, '{1'b1, 3'd0, 8'h00, 8'h00, 8'h00}));
    plan.push_back(known_row(17'd32768, '{1'b1, 3'd0, 8'd127, 8'd127, 8'd127}));
    plan.push_back(known_row(17'd65535, '{1'b1, 3'd0, 8'hFF, 8'hFF, 8'hFF}));
    plan.push_back(known_row(17'd65536, '0));
    plan.push_back(sample_row(17'd65537));
    plan.push_back(known_row(17'h1FFFF, '0));
    // full gradient, last stop at 1.0
    plan.push_back(cfg_row(REG_STOP_COUNT, WORD_W'(7)));
    plan.push_back(cfg_row(REG_STOP_WORD0 + 3'd0, stop_word(17'd0, 24'h000000)));
    plan.push_back(cfg_row(REG_STOP_WORD0 + 3'd1, stop_word(17'd10000, 24'hFFFFFF)));
    plan.push_back(cfg_row(REG_STOP_WORD0 + 3'd2, stop_word(17'd20000, 24'hFF0000)));
    plan.push_back(cfg_row(REG_STOP_WORD0 + 3'd3, stop_word(17'd30000, 24'h00FF00)));
    plan.push_back(cfg_row(REG_STOP_WORD0 + 3'd4, stop_word(17'd40000, 24'h0000FF)));
    plan.push_back(cfg_row(REG_STOP_WORD0 + 3'd5, stop_word(17'd50000, 24'h123456)));
    plan.push_back(cfg_row(REG_STOP_WORD0 + 3'd6, stop_word(17'd65536, 24'hFEDCBA)));
    plan.push_back(known_row(17'd10000, '{1'b1, 3'd0, 8'hFF, 8'hFF, 8'hFF}));
    plan.push_back(sample_row(17'd10001));
    plan.push_back(sample_row(17'd25000));
    plan.push_back(sample_row(17'd50000));
    plan.push_back(known_row(17'd65536, '{1'b1, 3'd5, 8'hFE, 8'hDC, 8'hBA}));
    plan.push_back(known_row(17'd0, '0));
    plan.push_back(known_row(17'h1FFFF, '0));
    // out-of-order stop: segment 1 can never match
    plan.push_back(cfg_row(REG_STOP_WORD0 + 3'd2, stop_word(17'd5000, 24'hFF0000)));
    plan.push_back(sample_row(17'd7000));
    plan.push_back(sample_row(17'd15000));
    plan.push_back(sample_row(17'd30000));
    // too few stops
    plan.push_back(cfg_row(REG_STOP_COUNT, WORD_W'(0)));
    plan.push_back(known_row(17'd5000, '0));
    plan.push_back(cfg_row(REG_STOP_COUNT, WORD_W'(1)));
    plan.push_back(known_row(17'd5000, '0));
    // first stop at the top of the position range
    plan.push_back(cfg_row(REG_STOP_COUNT, WORD_W'(2)));
    plan.push_back(cfg_row(REG_STOP_WORD0, '1));
    plan.push_back(known_row(17'd65536, '0));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        pause_and_drain();
        cfg_write(plan[i].reg_idx, plan[i].wdata);
      end else begin
        send_sample(plan[i].sample, plan[i].known, plan[i].want);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      pause_and_drain();
      calm = (p == 3);
      if (p % 4 == 3 && p != NUM_PHASES - 1) begin
        cfg_write(REG_STOP_COUNT, WORD_W'($urandom_range(0, 7)));
        for (int s = 0; s < NUM_STOPS; s++)
          cfg_write(REG_STOP_WORD0 + IDX_W'(s), WORD_W'({$urandom, $urandom}));
      end else begin
        n = (p == 1) ? 2 : (p == NUM_PHASES - 1) ? NUM_STOPS : $urandom_range(2, NUM_STOPS);
        pos_q.delete();
        for (int s = 0; s < int'(n); s++) pos_q.push_back($urandom_range(0, 65536));
        pos_q.sort();
        if ($urandom_range(0, 1)) pos_q[0] = 0;
        if ($urandom_range(0, 1)) pos_q[n-1] = 65536;
        cfg_write(REG_STOP_COUNT, WORD_W'(n));
        for (int s = 0; s < NUM_STOPS; s++) begin
          w = (s < int'(n)) ? stop_word(POS_W'(pos_q[s]), RGB_W'($urandom))
                            : WORD_W'({$urandom, $urandom});
          cfg_write(REG_STOP_WORD0 + IDX_W'(s), w);
        end
      end
      if (p == 2) rx_hold_req = 1'b1;
      for (int j = 0; j < int'(PHASE_ITEMS); j++) begin
        if (p == 4 && j == PHASE_ITEMS / 2) pause_and_drain();
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          v = POS_W'($urandom_range(0, 131071));
        end else if (pick == 1) begin
          k = $urandom_range(0, NUM_STOPS - 1);
          v = map_word[k][WORD_W-1:RGB_W] + POS_W'($urandom_range(0, 1));
        end else begin
          v = POS_W'($urandom_range(0, 65536));
        end
        send_sample(v, 1'b0, '0);
      end
    end

    pause_and_drain();
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
